/* rtl/dpq_pkg.sv */
// Shared types, sizes, codes and address helpers for the distance priority queue.
// Used by dpq_scan, the top level and the testbench; depends on nothing.
package dpq_pkg;

	localparam int QUEUE_DEPTH   = 64;
	localparam int VISITED_DEPTH = 64;
	localparam int NODE_BITS     = 16;
	localparam int DIST_W        = 31;

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int VAW = $clog2(VISITED_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int VCW = $clog2(VISITED_DEPTH + 1);
	localparam int SCW = (QCW > VCW) ? QCW : VCW;

	localparam logic [DIST_W-1:0] DIST_ABSENT = {DIST_W{1'b1}};

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_VIS = 3'd1;
	localparam logic [2:0] OP_REM = 3'd2;
	localparam logic [2:0] OP_UPD = 3'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_QFULL    = 2'd1;
	localparam logic [1:0] STAT_VFULL    = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [NODE_BITS-1:0] node;
		logic [DIST_W-1:0]    dval;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                 clear;
		logic                 f_vld;
		logic                 v_vld;
		logic                 first;
		logic [NODE_BITS-1:0] key;
	} scan_ctl_t;

	typedef struct packed {
		logic                 sorted;
		logic [NODE_BITS-1:0] lowest_node;
		logic [DIST_W-1:0]    head_dist;
		logic [DIST_W-1:0]    vhead_dist;
		logic                 queued;
		logic                 visited;
		logic [DIST_W-1:0]    node_dist;
	} scan_res_t;

	// Logical position to physical slot of the circular frontier store.
	function automatic logic [QAW-1:0] f_addr(input logic [QAW-1:0] head,
			input logic [QAW-1:0] idx);
		logic [QAW:0] sum;
		sum = {1'b0, head} + {1'b0, idx};
		if (sum >= (QAW+1)'(QUEUE_DEPTH))
			sum = sum - (QAW+1)'(QUEUE_DEPTH);
		return sum[QAW-1:0];
	endfunction

	function automatic logic [VAW-1:0] v_addr(input logic [VAW-1:0] head,
			input logic [VAW-1:0] idx);
		logic [VAW:0] sum;
		sum = {1'b0, head} + {1'b0, idx};
		if (sum >= (VAW+1)'(VISITED_DEPTH))
			sum = sum - (VAW+1)'(VISITED_DEPTH);
		return sum[VAW-1:0];
	endfunction

endpackage

/* rtl/dpq_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; used for the frontier and visited stores.
module dpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

/* rtl/dpq_scan.sv */
// Result accumulator fed one frontier and one visited entry per beat of the walk.
// Depends on dpq_pkg.
module dpq_scan (
	input  logic              clk,
	input  dpq_pkg::scan_ctl_t ctl,
	input  dpq_pkg::entry_t    f_ent,
	input  dpq_pkg::entry_t    v_ent,
	output dpq_pkg::scan_res_t res
);
	import dpq_pkg::*;

	logic [DIST_W-1:0] prev_q;
	logic [DIST_W-1:0] min_q;
	scan_res_t         res_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			res_q.sorted      <= 1'b1;
			res_q.lowest_node <= '0;
			res_q.head_dist   <= '0;
			res_q.vhead_dist  <= '0;
			res_q.queued      <= 1'b0;
			res_q.visited     <= 1'b0;
			res_q.node_dist   <= DIST_ABSENT;
		end else begin
			if (ctl.f_vld) begin
				prev_q <= f_ent.dval;
				if (ctl.first) begin
					res_q.head_dist   <= f_ent.dval;
					min_q             <= f_ent.dval;
					res_q.lowest_node <= f_ent.node;
				end else begin
					if (prev_q > f_ent.dval)
						res_q.sorted <= 1'b0;
					if (f_ent.dval < min_q) begin
						min_q             <= f_ent.dval;
						res_q.lowest_node <= f_ent.node;
					end
				end
				if (!res_q.queued && f_ent.node == ctl.key) begin
					res_q.queued    <= 1'b1;
					res_q.node_dist <= f_ent.dval;
				end
			end
			if (ctl.v_vld) begin
				if (ctl.first)
					res_q.vhead_dist <= v_ent.dval;
				if (v_ent.node == ctl.key)
					res_q.visited <= 1'b1;
			end
		end
	end

	assign res = res_q;
endmodule

/* rtl/distance_priority_queue.sv */
// Top level of the distance priority queue: control sequencer and two list stores.
// Depends on dpq_pkg, dpq_ram and dpq_scan.

// A command is taken when start is high while busy is low; each command produces
// exactly one result beat, shown for a single cycle with done high, and the
// receiver cannot hold it off. Both lists live in circular single-write RAMs
// with a registered read, so prepends and head removals only move a pointer.
// Every command ends with a walk over both lists. An update first searches
// the frontier, then runs an in-place stable insertion sort through the
// frontier RAM: each element is read as the key, every greater entry below it
// is shifted one slot up, and the key is written into the slot left free.
// There is no clearing pass after reset; only entries below the fill count
// are ever read.
module distance_priority_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          op,
	input  logic [dpq_pkg::NODE_BITS-1:0]       node,
	input  logic [dpq_pkg::DIST_W-1:0]          dist_req,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [6:0]                          queue_size,
	output logic                                queue_sorted,
	output logic                                queue_empty,
	output logic [dpq_pkg::NODE_BITS-1:0]       lowest_node,
	output logic [dpq_pkg::DIST_W-1:0]          head_dist,
	output logic [dpq_pkg::DIST_W-1:0]          visited_head_dist,
	output logic                                node_queued,
	output logic                                node_visited,
	output logic [dpq_pkg::DIST_W-1:0]          node_dist
);
	import dpq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIND  = 3'd1;
	localparam logic [2:0] S_KEY   = 3'd2;
	localparam logic [2:0] S_KEYW  = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_PLACE = 3'd5;
	localparam logic [2:0] S_SCAN  = 3'd6;

	logic [2:0]           state_q;
	logic [QAW-1:0]       fhead_q;
	logic [QCW-1:0]       fcount_q;
	logic [VAW-1:0]       vhead_q;
	logic [VCW-1:0]       vcount_q;
	logic [NODE_BITS-1:0] node_q;
	logic [DIST_W-1:0]    dist_q;
	logic [1:0]           stat_q;
	logic                 found_q;
	logic [SCW-1:0]       k_q;
	logic                 vld_s1;
	logic [SCW-1:0]       idx_s1;
	logic [QCW-1:0]       i_q;
	logic [QAW-1:0]       j_q;
	entry_t               key_q;
	logic                 done_q;

	logic [1:0]           status_q;
	logic [QCW-1:0]       qsize_q;
	scan_res_t            out_q;

	logic                 f_we;
	logic [QAW-1:0]       f_waddr;
	entry_t               f_wdata;
	logic [QAW-1:0]       f_raddr;
	entry_t               f_rdata;
	logic                 v_we;
	logic [VAW-1:0]       v_waddr;
	entry_t               v_wdata;
	logic [VAW-1:0]       v_raddr;
	entry_t               v_rdata;

	scan_ctl_t            sctl;
	scan_res_t            sres;

	logic                 accept;
	logic                 f_full;
	logic                 v_full;
	logic [SCW-1:0]       scan_n;
	logic [QAW-1:0]       fhead_dec;
	logic [QAW-1:0]       fhead_inc;
	logic [VAW-1:0]       vhead_dec;
	logic                 greater;
	logic [QCW-1:0]       i_next;
	logic                 scan_end;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign f_full  = (fcount_q >= QCW'(QUEUE_DEPTH));
	assign v_full  = (vcount_q >= VCW'(VISITED_DEPTH));
	assign scan_n  = (SCW'(fcount_q) > SCW'(vcount_q)) ? SCW'(fcount_q) : SCW'(vcount_q);
	assign fhead_dec = (fhead_q == '0) ? QAW'(QUEUE_DEPTH - 1) : fhead_q - QAW'(1);
	assign fhead_inc = f_addr(fhead_q, QAW'(1));
	assign vhead_dec = (vhead_q == '0) ? VAW'(VISITED_DEPTH - 1) : vhead_q - VAW'(1);
	assign greater = (f_rdata.dval > key_q.dval);
	assign i_next  = i_q + QCW'(1);
	// The walk has issued every read and folded in the last one.
	assign scan_end = (state_q == S_SCAN) && (k_q == scan_n) && !vld_s1;

	dpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_front (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	dpq_ram #(.WIDTH(ENTRY_W), .DEPTH(VISITED_DEPTH)) u_visit (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// The walk accumulators stay cleared whenever the walk is not running.
	assign sctl.clear = (state_q != S_SCAN);
	assign sctl.f_vld = vld_s1 && (idx_s1 < SCW'(fcount_q));
	assign sctl.v_vld = vld_s1 && (idx_s1 < SCW'(vcount_q));
	assign sctl.first = (idx_s1 == '0);
	assign sctl.key   = node_q;

	dpq_scan u_scan (
		.clk   (clk),
		.ctl   (sctl),
		.f_ent (f_rdata),
		.v_ent (v_rdata),
		.res   (sres)
	);

	// Memory port steering. During the sort the shifted entry is written one
	// slot up while the next lower slot is read, so the two never collide.
	always_comb begin
		f_we    = 1'b0;
		f_waddr = '0;
		f_wdata = '0;
		f_raddr = f_addr(fhead_q, k_q[QAW-1:0]);
		v_we    = 1'b0;
		v_waddr = vhead_dec;
		v_wdata = '0;
		v_raddr = v_addr(vhead_q, k_q[VAW-1:0]);
		unique case (state_q)
			S_IDLE: begin
				if (accept && op == OP_ADD && !f_full) begin
					f_we    = 1'b1;
					f_waddr = fhead_dec;
					f_wdata = '{node: node, dval: dist_req};
				end
				if (accept && op == OP_VIS && !v_full) begin
					v_we    = 1'b1;
					v_wdata = '{node: node, dval: dist_req};
				end
			end
			S_FIND: begin
				if (vld_s1 && !found_q && f_rdata.node == node_q) begin
					f_we    = 1'b1;
					f_waddr = f_addr(fhead_q, idx_s1[QAW-1:0]);
					f_wdata = '{node: f_rdata.node, dval: dist_q};
				end
			end
			S_KEY: begin
				f_raddr = f_addr(fhead_q, i_q[QAW-1:0]);
			end
			S_KEYW: begin
				f_raddr = f_addr(fhead_q, i_q[QAW-1:0] - QAW'(1));
			end
			S_CMP: begin
				f_we    = 1'b1;
				f_waddr = f_addr(fhead_q, j_q);
				f_wdata = greater ? f_rdata : key_q;
				f_raddr = f_addr(fhead_q, j_q - QAW'(2));
			end
			S_PLACE: begin
				f_we    = 1'b1;
				f_waddr = fhead_q;
				f_wdata = key_q;
			end
			S_SCAN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fhead_q  <= '0;
			fcount_q <= '0;
			vhead_q  <= '0;
			vcount_q <= '0;
			done_q   <= 1'b0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			k_q      <= '0;
		end else begin
			done_q <= scan_end;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						node_q  <= node;
						dist_q  <= dist_req;
						k_q     <= '0;
						vld_s1  <= 1'b0;
						found_q <= 1'b0;
						unique case (op)
							OP_ADD: begin
								state_q <= S_SCAN;
								if (f_full) begin
									stat_q <= STAT_QFULL;
								end else begin
									stat_q   <= STAT_OK;
									fhead_q  <= fhead_dec;
									fcount_q <= fcount_q + QCW'(1);
								end
							end
							OP_VIS: begin
								state_q <= S_SCAN;
								if (v_full) begin
									stat_q <= STAT_VFULL;
								end else begin
									stat_q   <= STAT_OK;
									vhead_q  <= vhead_dec;
									vcount_q <= vcount_q + VCW'(1);
								end
							end
							OP_REM: begin
								state_q <= S_SCAN;
								stat_q  <= STAT_OK;
								if (fcount_q != '0) begin
									fhead_q  <= fhead_inc;
									fcount_q <= fcount_q - QCW'(1);
								end
							end
							OP_UPD: begin
								stat_q  <= STAT_NOTFOUND;
								state_q <= S_FIND;
							end
							default: begin
								stat_q  <= STAT_OK;
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_FIND: begin
					if (k_q < SCW'(fcount_q) && !found_q) begin
						k_q    <= k_q + SCW'(1);
						vld_s1 <= 1'b1;
						idx_s1 <= k_q;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && !found_q && f_rdata.node == node_q) begin
						found_q <= 1'b1;
						stat_q  <= STAT_OK;
					end
					if (!vld_s1 && (k_q == SCW'(fcount_q) || found_q)) begin
						k_q <= '0;
						if (fcount_q <= QCW'(1)) begin
							state_q <= S_SCAN;
						end else begin
							i_q     <= QCW'(1);
							state_q <= S_KEY;
						end
					end
				end
				S_KEY: begin
					state_q <= S_KEYW;
				end
				S_KEYW: begin
					key_q   <= f_rdata;
					j_q     <= i_q[QAW-1:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (greater) begin
						if (j_q > QAW'(1)) begin
							j_q <= j_q - QAW'(1);
						end else begin
							j_q     <= '0;
							state_q <= S_PLACE;
						end
					end else begin
						i_q     <= i_next;
						state_q <= (i_next < fcount_q) ? S_KEY : S_SCAN;
					end
				end
				S_PLACE: begin
					i_q     <= i_next;
					state_q <= (i_next < fcount_q) ? S_KEY : S_SCAN;
				end
				S_SCAN: begin
					if (k_q < scan_n) begin
						k_q    <= k_q + SCW'(1);
						vld_s1 <= 1'b1;
						idx_s1 <= k_q;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (scan_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result beat registers, loaded as the walk finishes.
	always_ff @(posedge clk) begin
		if (scan_end) begin
			status_q <= stat_q;
			qsize_q  <= fcount_q;
			out_q    <= sres;
		end
	end

	assign done              = done_q;
	assign status            = status_q;
	assign queue_size        = 7'(qsize_q);
	assign queue_sorted      = out_q.sorted;
	assign queue_empty       = (qsize_q == '0);
	assign lowest_node       = out_q.lowest_node;
	assign head_dist         = out_q.head_dist;
	assign visited_head_dist = out_q.vhead_dist;
	assign node_queued       = out_q.queued;
	assign node_visited      = out_q.visited;
	assign node_dist         = out_q.node_dist;

`ifndef SYNTHESIS
	a_fcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= QCW'(QUEUE_DEPTH))
		else $error("frontier count beyond depth");
	a_vcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= VCW'(VISITED_DEPTH))
		else $error("visited count beyond depth");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still working");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted command did not start");
	a_sort_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (QCW'(j_q) < fcount_q && j_q != '0))
		else $error("sort index outside the frontier");
`endif
endmodule

/* sim/tb_distance_priority_queue.sv */
`timescale 1ns / 100ps
// Self-checking testbench for distance_priority_queue: directed corner cases and random
// command streams. Depends on dpq_pkg and the RTL of the block.
module tb_distance_priority_queue;
	import dpq_pkg::*;

	// The package names only four operation codes. Query and the three unused codes are
	// named here.
	localparam logic [2:0] OP_QRY  = 3'd4;
	localparam logic [2:0] OP_SPR5 = 3'd5;
	localparam logic [2:0] OP_SPR6 = 3'd6;
	localparam logic [2:0] OP_SPR7 = 3'd7;
	localparam int          WD_LIMIT = 40000;
	localparam logic [DIST_W-1:0] DIST_TOP = 31'h7FFF_FFFE;

	typedef struct {
		logic [1:0]           status;
		logic [6:0]           qsize;
		logic                 sorted;
		logic                 empty;
		logic [NODE_BITS-1:0] mnode;
		logic [DIST_W-1:0]    hdist;
		logic [DIST_W-1:0]    vhdist;
		logic                 queued;
		logic                 visited;
		logic [DIST_W-1:0]    ndist;
	} outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [2:0]           op = '0;
	logic [NODE_BITS-1:0] node = '0;
	logic [DIST_W-1:0]    dist_req = '0;
	logic                 busy, done;
	logic [1:0]           status;
	logic [6:0]           queue_size;
	logic                 queue_sorted, queue_empty;
	logic [NODE_BITS-1:0] lowest_node;
	logic [DIST_W-1:0]    head_dist, visited_head_dist, node_dist;
	logic                 node_queued, node_visited;

	distance_priority_queue DUT (.*);

	always #2 clk = ~clk;

	// Mirror of the two lists, index 0 being the head of each.
	logic [NODE_BITS-1:0] fr_node [QUEUE_DEPTH];
	logic [DIST_W-1:0]    fr_dist [QUEUE_DEPTH];
	int                   fr_cnt;
	logic [NODE_BITS-1:0] vs_node [VISITED_DEPTH];
	logic [DIST_W-1:0]    vs_dist [VISITED_DEPTH];
	int                   vs_cnt;

	outcome_t             pending_results [$];
	logic [NODE_BITS-1:0] node_pool [32];
	int                   errors = 0;
	int                   idle_cycles = 0;
	bit                   gaps_on = 1'b1;

	// Stable insertion sort of the frontier by ascending distance.
	function automatic void resort_frontier();
		logic [NODE_BITS-1:0] kn;
		logic [DIST_W-1:0]    kd;
		int                   j;
		for (int i = 1; i < fr_cnt; i++) begin
			kn = fr_node[i];
			kd = fr_dist[i];
			j = i;
			while (j > 0 && fr_dist[j-1] > kd) begin
				fr_node[j] = fr_node[j-1];
				fr_dist[j] = fr_dist[j-1];
				j--;
			end
			fr_node[j] = kn;
			fr_dist[j] = kd;
		end
	endfunction

	// Applies one command to the mirror and returns the result beat it must produce.
	function automatic outcome_t apply_command(logic [2:0] c, logic [NODE_BITS-1:0] n,
			logic [DIST_W-1:0] d);
		outcome_t r;
		logic [DIST_W-1:0] mind;
		r = '{status: STAT_OK, qsize: '0, sorted: 1'b1, empty: 1'b0, mnode: '0, hdist: '0,
			vhdist: '0, queued: 1'b0, visited: 1'b0, ndist: DIST_ABSENT};
		mind = '0;
		case (c)
			OP_ADD: begin
				if (fr_cnt >= QUEUE_DEPTH)
					r.status = STAT_QFULL;
				else begin
					for (int i = fr_cnt; i > 0; i--) begin
						fr_node[i] = fr_node[i-1];
						fr_dist[i] = fr_dist[i-1];
					end
					fr_node[0] = n;
					fr_dist[0] = d;
					fr_cnt++;
				end
			end
			OP_VIS: begin
				if (vs_cnt >= VISITED_DEPTH)
					r.status = STAT_VFULL;
				else begin
					for (int i = vs_cnt; i > 0; i--) begin
						vs_node[i] = vs_node[i-1];
						vs_dist[i] = vs_dist[i-1];
					end
					vs_node[0] = n;
					vs_dist[0] = d;
					vs_cnt++;
				end
			end
			OP_REM: begin
				if (fr_cnt > 0) begin
					for (int i = 1; i < fr_cnt; i++) begin
						fr_node[i-1] = fr_node[i];
						fr_dist[i-1] = fr_dist[i];
					end
					fr_cnt--;
				end
			end
			OP_UPD: begin
				// Only the first match is rewritten; the list is re-sorted even when
				// nothing matched.
				r.status = STAT_NOTFOUND;
				for (int i = 0; i < fr_cnt; i++) begin
					if (fr_node[i] == n) begin
						fr_dist[i] = d;
						r.status = STAT_OK;
						break;
					end
				end
				resort_frontier();
			end
			default: ;
		endcase
		for (int i = 0; i < fr_cnt; i++) begin
			if (i > 0 && fr_dist[i-1] > fr_dist[i])
				r.sorted = 1'b0;
			if (i == 0 || fr_dist[i] < mind) begin
				mind = fr_dist[i];
				r.mnode = fr_node[i];
			end
			if (!r.queued && fr_node[i] == n) begin
				r.queued = 1'b1;
				r.ndist = fr_dist[i];
			end
		end
		for (int i = 0; i < vs_cnt; i++)
			if (vs_node[i] == n)
				r.visited = 1'b1;
		r.qsize = 7'(fr_cnt);
		r.empty = (fr_cnt == 0);
		r.hdist = (fr_cnt > 0) ? fr_dist[0] : '0;
		r.vhdist = (vs_cnt > 0) ? vs_dist[0] : '0;
		return r;
	endfunction

	// Offers one command beat and holds it until the block takes it. Start is left high
	// so that a following beat can go out back to back.
	task automatic send_command(logic [2:0] c, logic [NODE_BITS-1:0] n, logic [DIST_W-1:0] d);
		start <= 1'b1;
		op <= c;
		node <= n;
		dist_req <= d;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(apply_command(c, n, d));
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Holds the command side off until every outstanding result beat has been seen.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [NODE_BITS-1:0] pick_node();
		if ($urandom_range(0, 9) < 7)
			return node_pool[$urandom_range(0, 31)];
		return NODE_BITS'($urandom);
	endfunction

	function automatic logic [DIST_W-1:0] pick_dist();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIST_TOP;
			2: return DIST_W'($urandom_range(0, 15));
			default: return DIST_W'($urandom_range(0, 32'h7FFF_FFFE));
		endcase
	endfunction

	function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// Every done cycle is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no command outstanding");
				errors++;
			end else begin
				w = pending_results.pop_front();
				report_field("status", w.status, status);
				report_field("queue_size", w.qsize, queue_size);
				report_field("queue_sorted", w.sorted, queue_sorted);
				report_field("queue_empty", w.empty, queue_empty);
				report_field("lowest_node", w.mnode, lowest_node);
				report_field("head_dist", w.hdist, head_dist);
				report_field("visited_head_dist", w.vhdist, visited_head_dist);
				report_field("node_queued", w.queued, node_queued);
				report_field("node_visited", w.visited, node_visited);
				report_field("node_dist", w.ndist, node_dist);
			end
		end
	end

	// Watchdog: counts cycles in which neither a command nor a result beat moves.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Empty-list behaviour: removal, update and query with nothing queued, plus the
	// unused operation codes, which must act as queries.
	task automatic test_empty_lists();
		send_command(OP_QRY, '0, '0);
		send_command(OP_REM, 16'hFFFF, DIST_TOP);
		send_command(OP_UPD, 16'h1234, 31'd5);
		send_command(OP_SPR5, 16'hFFFF, '0);
		send_command(OP_SPR6, '0, DIST_TOP);
		send_command(OP_SPR7, 16'h5555, 31'h2AAA_AAAA);
	endtask

	// Field extremes, a tie on distance, an absent update and a duplicate node.
	task automatic test_extremes();
		send_command(OP_ADD, 16'hFFFF, DIST_TOP);
		send_command(OP_ADD, '0, '0);
		send_command(OP_ADD, 16'hFFFF, 31'd7);
		send_command(OP_VIS, 16'hFFFF, DIST_TOP);
		send_command(OP_VIS, '0, '0);
		send_command(OP_QRY, 16'hFFFF, '0);
		send_command(OP_UPD, 16'hFFFF, '0);
		send_command(OP_UPD, 16'hABCD, 31'd1);
		send_command(OP_ADD, 16'h00AA, DIST_TOP);
		send_command(OP_UPD, '0, DIST_TOP);
		send_command(OP_QRY, '0, '0);
		send_command(OP_REM, '0, '0);
		send_command(OP_REM, '0, '0);
		send_command(OP_REM, '0, '0);
		send_command(OP_REM, '0, '0);
		send_command(OP_QRY, 16'hFFFF, '0);
	endtask

	// Random command mix. The add and remove weights move with add_bias so that the
	// frontier is walked both towards full and towards empty.
	task automatic test_random_mix(int count, int add_bias);
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < add_bias)
				send_command(OP_ADD, pick_node(), pick_dist());
			else if (r < add_bias + 5)
				send_command(OP_VIS, pick_node(), pick_dist());
			else if (r < 60)
				send_command(OP_REM, pick_node(), pick_dist());
			else if (r < 80)
				send_command(OP_UPD, pick_node(), pick_dist());
			else if (r < 96)
				send_command(OP_QRY, pick_node(), pick_dist());
			else
				send_command(3'($urandom_range(OP_SPR5, OP_SPR7)), pick_node(), pick_dist());
		end
	endtask

	// Fills the frontier past its depth so that adds are refused, updates a full list,
	// then empties it again.
	task automatic test_frontier_full();
		while (fr_cnt < QUEUE_DEPTH)
			send_command(OP_ADD, pick_node(), pick_dist());
		send_command(OP_ADD, 16'h0F0F, '0);
		send_command(OP_UPD, fr_node[QUEUE_DEPTH-1], '0);
		send_command(OP_QRY, fr_node[0], '0);
		send_command(OP_ADD, 16'hF0F0, DIST_TOP);
		while (fr_cnt > 0)
			send_command(OP_REM, pick_node(), pick_dist());
		send_command(OP_REM, '0, '0);
	endtask

	// Fills the visited list; once full, further visits are refused.
	task automatic test_visited_full();
		while (vs_cnt < VISITED_DEPTH)
			send_command(OP_VIS, pick_node(), pick_dist());
		send_command(OP_VIS, 16'hFFFF, DIST_TOP);
		send_command(OP_QRY, vs_node[VISITED_DEPTH-1], '0);
	endtask

	initial begin
		fr_cnt = 0;
		vs_cnt = 0;
		foreach (node_pool[i])
			node_pool[i] = NODE_BITS'($urandom);
		node_pool[0] = '0;
		node_pool[1] = 16'hFFFF;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lists();
		test_extremes();
		drain_results();
		test_random_mix(300, 45);
		test_random_mix(200, 25);
		test_frontier_full();
		test_random_mix(250, 40);
		test_visited_full();
		gaps_on = 1'b0;
		test_random_mix(150, 35);

		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* distance_priority_queue.f */
rtl/dpq_pkg.sv
rtl/dpq_ram.sv
rtl/dpq_scan.sv
rtl/distance_priority_queue.sv
sim/tb_distance_priority_queue.sv
